[sv/assert_macros.svh]
// assertion macros used by the format printer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define ASSERT_SAME(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds in this cycle, consequent in the next one
`define ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mfp_pkg.sv]
// constants and character tables for the format printer
`default_nettype none

package mfp_pkg;

	localparam int COUNT_BITS  = 16;
	localparam int TOTAL_BITS  = 16;
	localparam int ARG_BITS    = 32;
	localparam int DEC_DIGITS  = 10;
	localparam int HEX_NIBBLES = ARG_BITS / 4;
	localparam int DIG_BITS    = 4 * DEC_DIGITS;
	localparam int NULL_LEN    = 6;

	localparam logic [2:0] FN_FMT  = 3'd0;
	localparam logic [2:0] FN_INT  = 3'd1;
	localparam logic [2:0] FN_STR  = 3'd2;
	localparam logic [2:0] FN_END  = 3'd3;
	localparam logic [2:0] FN_NULL = 3'd4;
	localparam logic [2:0] FN_NEW  = 3'd5;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_D       = 8'h64;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_S       = 8'h73;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_NUL     = 8'h00;

	localparam logic [7:0] HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	localparam logic [7:0] NULL_TEXT [NULL_LEN] = '{
		8'h28, 8'h6e, 8'h75, 8'h6c, 8'h6c, 8'h29
	};

endpackage

`default_nettype wire

[sv/mini_format_printer.sv]
// small formatted-output engine: literals, signed decimal, hex and strings
//
//  channel | signals                                  | role
//  --------+------------------------------------------+---------------------------
//  in      | in_valid in_ready func data_byte arg_value | format bytes and arguments
//  out     | out_valid out_ready out_char last total_chars | characters with count
//
// literal or string byte: one character; null string: the six characters of (null)
// decimal: optional minus sign, bit-serial double dabble over the 32 argument bits,
//   leading-zero skip, then one digit per cycle while out_ready does not stall
// hex: leading-zero skip, then one digit per cycle while out_ready does not stall
// arst_n clears the state, the parse mode, the count and the output valid flag
// a stalled out_ready holds dig_q in ST_DIGIT; in_ready is low until an item is done
`default_nettype none

module mini_format_printer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [2:0]                       func,
	input  wire logic [7:0]                       data_byte,
	input  wire logic signed [mfp_pkg::ARG_BITS-1:0] arg_value,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [7:0]                            out_char,
	output logic                                  last,
	output logic [mfp_pkg::TOTAL_BITS-1:0]        total_chars
);
	import mfp_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHAR, ST_NULL, ST_SIGN, ST_CONV, ST_SKIP, ST_DIGIT
	} state_t;

	typedef enum logic [2:0] {
		MD_LITERAL, MD_PERCENT, MD_WAIT_DEC, MD_WAIT_HEX, MD_STRING
	} mode_t;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t                  state_q;
	mode_t                   mode_q;
	logic [7:0]              char_q;
	logic [2:0]              idx_q;
	logic [4:0]              cnt_q;
	logic [3:0]              ndig_q;
	logic [DIG_BITS-1:0]     dig_q;
	logic [ARG_BITS-1:0]     bin_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic                    out_valid_q;
	logic [7:0]              out_char_q;
	logic                    last_q;
	logic [TOTAL_BITS-1:0]   total_q;

	logic                    in_acc;
	logic                    em_req;
	logic                    em_fire;
	logic [7:0]              em_char;
	logic                    em_last;
	logic [COUNT_BITS-1:0]   count_inc;
	logic [DIG_BITS-1:0]     dd_adj;
	logic [ARG_BITS-1:0]     arg_u;
	logic [ARG_BITS-1:0]     arg_mag;
	logic                    conv_end;
	logic                    skip_start;
	logic                    new_acc;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last        = last_q;
	assign total_chars = total_q;

	assign arg_u     = arg_value;
	assign arg_mag   = ~arg_u + ARG_BITS'(1);
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_BITS'(1);
	assign em_fire   = em_req && (!out_valid_q || out_ready);

	assign conv_end   = (state_q == ST_CONV) && (cnt_q == 5'(ARG_BITS - 1));
	assign skip_start = (state_q == ST_SKIP) && (ndig_q == 4'(DEC_DIGITS));
	assign new_acc    = in_acc && (func == FN_NEW);

	// add-3 correction on every bcd digit
	always_comb begin
		logic [3:0] d;
		dd_adj = dig_q;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			d = dig_q[4*i +: 4];
			dd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	always_comb begin
		em_req  = 1'b0;
		em_char = char_q;
		em_last = 1'b0;
		unique case (state_q)
			ST_CHAR: begin
				em_req  = 1'b1;
				em_last = 1'b1;
			end
			ST_NULL: begin
				em_req  = 1'b1;
				em_char = NULL_TEXT[idx_q];
				em_last = (idx_q == 3'(NULL_LEN - 1));
			end
			ST_SIGN: begin
				em_req  = 1'b1;
				em_char = CH_MINUS;
			end
			ST_DIGIT: begin
				em_req  = 1'b1;
				em_char = HEX_DIGITS[dig_q[DIG_BITS-1 -: 4]];
				em_last = (ndig_q == 4'd1);
			end
			default: begin
				em_req = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MD_LITERAL;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (em_fire) begin
				out_valid_q <= 1'b1;
				out_char_q  <= em_char;
				last_q      <= em_last;
				total_q     <= TOTAL_BITS'(count_inc);
				count_q     <= count_inc;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (func)
							FN_FMT: begin
								if (mode_q == MD_PERCENT) begin
									case (data_byte)
										CH_D:    mode_q <= MD_WAIT_DEC;
										CH_X:    mode_q <= MD_WAIT_HEX;
										CH_S:    mode_q <= MD_STRING;
										default: mode_q <= MD_LITERAL;
									endcase
								end else if (data_byte == CH_PERCENT) begin
									mode_q <= MD_PERCENT;
								end else begin
									mode_q  <= MD_LITERAL;
									char_q  <= data_byte;
									state_q <= ST_CHAR;
								end
							end
							FN_INT: begin
								if (mode_q == MD_WAIT_DEC) begin
									mode_q <= MD_LITERAL;
									bin_q  <= arg_u[ARG_BITS-1] ? arg_mag : arg_u;
									dig_q  <= '0;
									cnt_q  <= '0;
									state_q <= arg_u[ARG_BITS-1] ? ST_SIGN : ST_CONV;
								end else if (mode_q == MD_WAIT_HEX) begin
									mode_q  <= MD_LITERAL;
									dig_q   <= {arg_u, (DIG_BITS - ARG_BITS)'(0)};
									ndig_q  <= 4'(HEX_NIBBLES);
									state_q <= ST_SKIP;
								end
							end
							FN_STR: begin
								if (mode_q == MD_STRING) begin
									if (data_byte == CH_NUL) begin
										mode_q <= MD_LITERAL;
									end else begin
										char_q  <= data_byte;
										state_q <= ST_CHAR;
									end
								end
							end
							FN_END: begin
								if (mode_q == MD_STRING) begin
									mode_q <= MD_LITERAL;
								end
							end
							FN_NULL: begin
								if (mode_q == MD_STRING) begin
									mode_q  <= MD_LITERAL;
									idx_q   <= '0;
									state_q <= ST_NULL;
								end
							end
							FN_NEW: begin
								mode_q  <= MD_LITERAL;
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHAR: begin
					if (em_fire) begin
						state_q <= ST_IDLE;
					end
				end
				ST_NULL: begin
					if (em_fire) begin
						if (em_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_SIGN: begin
					if (em_fire) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					dig_q <= {dd_adj[DIG_BITS-2:0], bin_q[ARG_BITS-1]};
					bin_q <= bin_q << 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(ARG_BITS - 1)) begin
						ndig_q  <= 4'(DEC_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (dig_q[DIG_BITS-1 -: 4] == 4'd0 && ndig_q > 4'd1) begin
						dig_q  <= dig_q << 4;
						ndig_q <= ndig_q - 4'd1;
					end else begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (em_fire) begin
						dig_q  <= dig_q << 4;
						ndig_q <= ndig_q - 4'd1;
						if (em_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_SAME(a_digit_left, clk, arst_n, state_q == ST_DIGIT, ndig_q != 4'd0, "no digit left")
	`ASSERT_NEXT(a_conv_done, clk, arst_n, conv_end, skip_start, "conversion did not hand over")
	`ASSERT_NEXT(a_count_mono, clk, arst_n, !new_acc, count_q >= $past(count_q), "count went down")

endmodule

`default_nettype wire

[test/tb.sv]
// self-checking testbench for the format printer: directed, random and back-pressure
module tb;
	import mfp_pkg::*;

	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_H = 8'h68;
	localparam logic [7:0] CH_Z = 8'h5a;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
	localparam int RANDOM_ITEMS = 165;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef enum logic [2:0] {
		PM_LIT,
		PM_PCT,
		PM_DEC,
		PM_HEX,
		PM_STR
	} parse_state_t;

	typedef struct packed {
		logic [7:0]            ch;
		logic                  fin;
		logic [TOTAL_BITS-1:0] total;
	} printed_char_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [2:0]                func = FN_NEW;
	logic [7:0]                data_byte = 8'h00;
	logic signed [ARG_BITS-1:0] arg_value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [7:0]                out_char;
	logic                      last;
	logic [TOTAL_BITS-1:0]     total_chars;

	parse_state_t              parse_state = PM_LIT;
	logic [COUNT_BITS-1:0]     char_total = '0;
	printed_char_t             pending_chars[$];
	printed_char_t             oldest;
	int                        errors = 0;
	int                        items_sent = 0;
	int                        cycle_count = 0;
	int                        hold_cycles = 0;
	bit                        tx_idle = 1'b1;
	bit                        rx_idle = 1'b1;

	mini_format_printer dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.func,
		.data_byte,
		.arg_value,
		.out_valid,
		.out_ready,
		.out_char,
		.last,
		.total_chars
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// expected characters

	task automatic put_char(input logic [7:0] ch);
		if (char_total != '1)
			char_total++;
		pending_chars.push_back('{ch, 1'b0, char_total[TOTAL_BITS-1:0]});
	endtask

	task automatic put_decimal(input logic [31:0] bits);
		logic [31:0] mag;
		logic [7:0]  dig [DEC_DIGITS];
		int          nd;
		nd = 0;
		mag = bits[31] ? (~bits + 32'd1) : bits;
		do begin
			dig[nd] = 8'h30 + 8'(mag % 32'd10);
			mag = mag / 32'd10;
			nd++;
		end while (mag != 0 && nd < DEC_DIGITS);
		if (bits[31])
			put_char(CH_MINUS);
		while (nd > 0) begin
			nd--;
			put_char(dig[nd]);
		end
	endtask

	task automatic put_hex(input logic [31:0] bits);
		int         sh;
		logic [3:0] nib;
		sh = 28;
		while (sh > 0 && ((bits >> sh) & 32'hf) == 0)
			sh -= 4;
		for (; sh >= 0; sh -= 4) begin
			nib = 4'((bits >> sh) & 32'hf);
			put_char(nib < 4'd10 ? 8'h30 + 8'(nib) : 8'h57 + 8'(nib));
		end
	endtask

	task automatic print_item(input logic [2:0] f, input logic [7:0] b, input logic [31:0] a);
		string         null_txt;
		int            prior_size;
		printed_char_t tail;
		null_txt = "(null)";
		prior_size = pending_chars.size();
		case (f)
			FN_FMT: begin
				if (parse_state == PM_PCT) begin
					case (b)
						CH_D:    parse_state = PM_DEC;
						CH_X:    parse_state = PM_HEX;
						CH_S:    parse_state = PM_STR;
						default: parse_state = PM_LIT;
					endcase
				end else if (b == CH_PERCENT) begin
					parse_state = PM_PCT;
				end else begin
					parse_state = PM_LIT;
					put_char(b);
				end
			end
			FN_INT: begin
				if (parse_state == PM_DEC) begin
					put_decimal(a);
					parse_state = PM_LIT;
				end else if (parse_state == PM_HEX) begin
					put_hex(a);
					parse_state = PM_LIT;
				end
			end
			FN_STR: begin
				if (parse_state == PM_STR) begin
					if (b == CH_NUL)
						parse_state = PM_LIT;
					else
						put_char(b);
				end
			end
			FN_END: begin
				if (parse_state == PM_STR)
					parse_state = PM_LIT;
			end
			FN_NULL: begin
				if (parse_state == PM_STR) begin
					for (int i = 0; i < NULL_LEN; i++)
						put_char(null_txt[i]);
					parse_state = PM_LIT;
				end
			end
			FN_NEW: begin
				parse_state = PM_LIT;
				char_total = '0;
			end
			default: ;
		endcase
		if (pending_chars.size() > prior_size) begin
			tail = pending_chars.pop_back();
			tail.fin = 1'b1;
			pending_chars.push_back(tail);
		end
	endtask

	// input side

	task automatic send_item(input logic [2:0] f, input logic [7:0] b, input logic [31:0] a);
		int gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		data_byte <= b;
		arg_value <= a;
		print_item(f, b, a);
		items_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_fmt(input logic [7:0] b);
		send_item(FN_FMT, b, $urandom);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	// output side

	initial begin
		int stall;
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 7) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && arst_n));
		end
	end

	task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
		errors++;
		$error("%s: expected %0h, got %0h", name, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				report_field("out_char (nothing expected)", 32'hffff_ffff, 32'(out_char));
			end else begin
				oldest = pending_chars.pop_front();
				if (out_char !== oldest.ch)
					report_field("out_char", 32'(oldest.ch), 32'(out_char));
				if (last !== oldest.fin)
					report_field("last", 32'(oldest.fin), 32'(last));
				if (total_chars !== oldest.total)
					report_field("total_chars", 32'(oldest.total), 32'(total_chars));
			end
		end
	end

	// tests

	function automatic logic [31:0] rand_arg();
		case ($urandom_range(0, 6))
			0:       return INT_MIN;
			1:       return INT_MAX;
			2:       return 32'($urandom_range(0, 99));
			3:       return -32'($urandom_range(1, 99));
			4:       return 32'h1 << (4 * $urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	task automatic test_literals();
		send_item(FN_NEW, 8'h00, 32'h0);
		send_fmt(8'h00);
		send_fmt(8'hff);
		send_item(FN_SPARE6, 8'hff, 32'hffff_ffff);
		send_item(FN_SPARE7, 8'h41, 32'h0);
		send_item(FN_INT, 8'h00, INT_MAX);
		send_fmt(CH_PERCENT);
		send_fmt(CH_PERCENT);
	endtask

	task automatic test_integers();
		send_fmt(CH_PERCENT);
		send_fmt(CH_D);
		send_item(FN_INT, 8'h00, INT_MIN);
		send_fmt(CH_PERCENT);
		send_fmt(CH_X);
		send_item(FN_INT, 8'h00, 32'hffff_ffff);
		send_fmt(CH_PERCENT);
		send_fmt(CH_X);
		send_item(FN_INT, 8'h00, 32'h0);
		send_fmt(CH_PERCENT);
		send_fmt(CH_D);
		send_fmt(CH_A);
	endtask

	task automatic test_strings();
		send_fmt(CH_PERCENT);
		send_fmt(CH_S);
		send_item(FN_STR, CH_H, 32'h0);
		send_item(FN_STR, 8'hff, 32'h0);
		send_item(FN_NULL, 8'h00, 32'h0);
		send_fmt(CH_PERCENT);
		send_fmt(CH_S);
		send_item(FN_STR, CH_NUL, 32'h0);
		send_fmt(CH_PERCENT);
		send_item(FN_NEW, 8'h00, 32'h0);
	endtask

	task automatic random_sequence();
		int n;
		case ($urandom_range(0, 9))
			0, 1: begin
				n = $urandom_range(0, 255);
				send_fmt(n == CH_PERCENT ? CH_A : 8'(n));
			end
			2, 3: begin
				send_fmt(CH_PERCENT);
				send_fmt(CH_D);
				send_item(FN_INT, 8'($urandom), rand_arg());
			end
			4, 5: begin
				send_fmt(CH_PERCENT);
				send_fmt(CH_X);
				send_item(FN_INT, 8'($urandom), rand_arg());
			end
			6, 7: begin
				send_fmt(CH_PERCENT);
				send_fmt(CH_S);
				repeat ($urandom_range(0, 6))
					send_item(FN_STR, 8'($urandom_range(1, 255)), $urandom);
				case ($urandom_range(0, 3))
					0: send_item(FN_END, 8'($urandom), $urandom);
					1: send_item(FN_NULL, 8'($urandom), $urandom);
					2: send_item(FN_STR, CH_NUL, $urandom);
					default: send_fmt(CH_Z);
				endcase
			end
			8: send_item(FN_NEW, 8'($urandom), $urandom);
			default: send_item(3'($urandom_range(0, 7)), 8'($urandom), $urandom);
		endcase
	endtask

	task automatic test_random();
		int stop_at;
		int next_toggle;
		stop_at = items_sent + RANDOM_ITEMS;
		next_toggle = items_sent + 30;
		while (items_sent < stop_at) begin
			random_sequence();
			if (items_sent >= next_toggle) begin
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
				next_toggle = items_sent + 30;
			end
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		tx_idle = 1'b0;
		repeat (4) begin
			send_fmt(CH_PERCENT);
			send_fmt(CH_D);
			send_item(FN_INT, 8'h00, INT_MIN);
			send_fmt(CH_A);
		end
		tx_idle = 1'b1;
		wait_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_literals();
		test_integers();
		test_strings();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
